// ===== hw/rtl/i2cblm_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// i2cblm_pkg
// Shared types and constants for the I2C bit-level master engine.
// -----------------------------------------------------------------------------
package i2cblm_pkg;

   localparam int unsigned HalfPeriodWidth = 16;
   localparam int unsigned BitsPerByte     = 8;
   localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 16'd5;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } command_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START_A  = 4'd1,
      PH_START_B  = 4'd2,
      PH_STOP_A   = 4'd3,
      PH_STOP_B   = 4'd4,
      PH_BIT_LOW  = 4'd5,
      PH_BIT_HIGH = 4'd6,
      PH_ACK_LOW  = 4'd7,
      PH_ACK_HIGH = 4'd8,
      PH_FINISH   = 4'd9
   } phase_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] write_byte;
      logic       send_nack;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_seen;
   } rsp_item_type;

endpackage

// ===== hw/rtl/i2cblm_engine.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// i2cblm_engine
// Bus sequencer: advances the command state by one tick per accepted item and
// produces that tick's line levels and status.
// -----------------------------------------------------------------------------
module i2cblm_engine (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_wr_en,
   input  logic [i2cblm_pkg::HalfPeriodWidth-1:0]      csr_wr_data,
   input  logic                                        tick_accept,
   input  i2cblm_pkg::req_item_type                    tick_item,
   output i2cblm_pkg::rsp_item_type                    tick_result
);

   localparam int unsigned HpW = i2cblm_pkg::HalfPeriodWidth;

   logic [HpW-1:0]              half_period_ff;
   i2cblm_pkg::phase_type       phase_ff, phase_in;
   logic [3:0]                  bit_count_ff, bit_count_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [HpW-1:0]              tick_count_ff, tick_count_in;
   i2cblm_pkg::command_type     command_ff, command_in;
   logic                        nack_ff, nack_in;
   logic                        scl_ff, scl_in;
   logic                        sda_ff, sda_in;
   logic                        ack_ff, ack_in;
   logic [7:0]                  read_ff, read_in;

   logic [HpW-1:0]              half_eff;
   logic [HpW:0]                tick_next;
   logic                        busy;
   logic                        done;
   logic                        is_write;
   logic                        start_cmd;

   always_comb begin
      half_eff  = (half_period_ff == '0) ? HpW'(1) : half_period_ff;
      start_cmd = (phase_ff == i2cblm_pkg::PH_IDLE) &&
                  (tick_item.action >= i2cblm_pkg::CMD_START) &&
                  (tick_item.action <= i2cblm_pkg::CMD_READ);

      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      tick_count_in = tick_count_ff;
      command_in    = command_ff;
      nack_in       = nack_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      ack_in        = ack_ff;
      read_in       = read_ff;
      busy          = 1'b0;
      done          = 1'b0;

      // load a new command, then run this tick on the loaded state
      if (start_cmd) begin
         command_in    = i2cblm_pkg::command_type'(tick_item.action);
         nack_in       = tick_item.send_nack;
         bit_count_in  = '0;
         tick_count_in = '0;
         shift_in      = (tick_item.action == i2cblm_pkg::CMD_WRITE) ?
                         tick_item.write_byte : 8'd0;
         if (tick_item.action == i2cblm_pkg::CMD_START)
            phase_in = i2cblm_pkg::PH_START_A;
         else if (tick_item.action == i2cblm_pkg::CMD_STOP)
            phase_in = i2cblm_pkg::PH_STOP_A;
         else
            phase_in = i2cblm_pkg::PH_BIT_LOW;
      end

      is_write  = (command_in == i2cblm_pkg::CMD_WRITE);
      tick_next = {1'b0, tick_count_in} + (HpW+1)'(1);

      if (phase_in == i2cblm_pkg::PH_FINISH) begin
         priority if (command_in == i2cblm_pkg::CMD_START) begin
            scl_in = 1'b0;
            sda_in = 1'b0;
         end else if (command_in == i2cblm_pkg::CMD_STOP) begin
            scl_in = 1'b1;
            sda_in = 1'b1;
         end else begin
            scl_in = 1'b0;
            sda_in = 1'b1;
         end
         phase_in      = i2cblm_pkg::PH_IDLE;
         tick_count_in = '0;
         done          = 1'b1;
      end else if (phase_in != i2cblm_pkg::PH_IDLE) begin
         busy = 1'b1;
         // drive the segment levels
         unique case (phase_in)
            i2cblm_pkg::PH_START_A: begin scl_in = 1'b1; sda_in = 1'b1; end
            i2cblm_pkg::PH_START_B: begin scl_in = 1'b1; sda_in = 1'b0; end
            i2cblm_pkg::PH_STOP_A:  begin scl_in = 1'b0; sda_in = 1'b0; end
            i2cblm_pkg::PH_STOP_B:  begin scl_in = 1'b1; sda_in = 1'b1; end
            i2cblm_pkg::PH_BIT_LOW, i2cblm_pkg::PH_BIT_HIGH: begin
               scl_in = (phase_in == i2cblm_pkg::PH_BIT_HIGH);
               sda_in = is_write ? shift_in[7] : 1'b1;
            end
            i2cblm_pkg::PH_ACK_LOW, i2cblm_pkg::PH_ACK_HIGH: begin
               scl_in = (phase_in == i2cblm_pkg::PH_ACK_HIGH);
               sda_in = is_write ? 1'b1 : nack_in;
            end
            default: begin end
         endcase

         if (tick_next >= {1'b0, half_eff}) begin
            // segment ends; sample on the last tick of scl high
            tick_count_in = '0;
            unique case (phase_in)
               i2cblm_pkg::PH_START_A: phase_in = i2cblm_pkg::PH_START_B;
               i2cblm_pkg::PH_STOP_A:  phase_in = i2cblm_pkg::PH_STOP_B;
               i2cblm_pkg::PH_START_B,
               i2cblm_pkg::PH_STOP_B:  phase_in = i2cblm_pkg::PH_FINISH;
               i2cblm_pkg::PH_BIT_LOW: phase_in = i2cblm_pkg::PH_BIT_HIGH;
               i2cblm_pkg::PH_BIT_HIGH: begin
                  shift_in     = {shift_in[6:0], (is_write ? 1'b0 : tick_item.sda_in)};
                  bit_count_in = bit_count_in + 4'd1;
                  phase_in     = (bit_count_in >= 4'(i2cblm_pkg::BitsPerByte)) ?
                                 i2cblm_pkg::PH_ACK_LOW : i2cblm_pkg::PH_BIT_LOW;
               end
               i2cblm_pkg::PH_ACK_LOW: phase_in = i2cblm_pkg::PH_ACK_HIGH;
               i2cblm_pkg::PH_ACK_HIGH: begin
                  if (is_write)
                     ack_in = ~tick_item.sda_in;
                  else
                     read_in = shift_in;
                  phase_in = i2cblm_pkg::PH_FINISH;
               end
               default: phase_in = i2cblm_pkg::PH_IDLE;
            endcase
         end else begin
            tick_count_in = tick_next[HpW-1:0];
         end
      end

      tick_result.scl_level   = scl_in;
      tick_result.sda_release = sda_in;
      tick_result.busy_res    = busy;
      tick_result.done_res    = done;
      tick_result.read_byte   = read_in;
      tick_result.ack_seen    = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= i2cblm_pkg::HalfPeriodReset;
         phase_ff       <= i2cblm_pkg::PH_IDLE;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         tick_count_ff  <= '0;
         command_ff     <= i2cblm_pkg::CMD_NONE;
         nack_ff        <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         ack_ff         <= 1'b0;
         read_ff        <= '0;
      end else begin
         if (csr_wr_en)
            half_period_ff <= csr_wr_data;
         if (tick_accept) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            shift_ff      <= shift_in;
            tick_count_ff <= tick_count_in;
            command_ff    <= command_in;
            nack_ff       <= nack_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            ack_ff        <= ack_in;
            read_ff       <= read_in;
         end
      end
   end

endmodule

// ===== hw/rtl/i2cblm_out_buffer.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// i2cblm_out_buffer
// Two-entry result buffer: output register plus skid register, so the input
// side keeps flowing while a result waits on a stalled receiver.
// -----------------------------------------------------------------------------
module i2cblm_out_buffer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  i2cblm_pkg::rsp_item_type  in_item,
   output logic                      out_valid,
   input  logic                      out_stall,
   output i2cblm_pkg::rsp_item_type  out_item
);

   logic                     out_valid_ff, out_valid_in;
   i2cblm_pkg::rsp_item_type out_item_ff, out_item_in;
   logic                     skid_valid_ff, skid_valid_in;
   i2cblm_pkg::rsp_item_type skid_item_ff, skid_item_in;
   logic                     in_take;
   logic                     out_free;

   always_comb begin
      in_take       = in_valid && !skid_valid_ff;
      out_free      = !out_valid_ff || !out_stall;
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_take;
            out_item_in  = in_item;
         end
      end else if (in_take) begin
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

// ===== hw/rtl/i2c_bit_level_master_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// i2c_bit_level_master_unit
// I2C master bit engine stepped once per item.
// -----------------------------------------------------------------------------
// Each accepted item is one bus tick: the engine updates its command state and
// line levels in the same cycle and the tick's result is registered in the
// output buffer. One item is taken every clock cycle; the only limit is the
// receiver, since a two-entry result buffer stalls the input only when both
// its entries hold results that have not been taken. Commands are taken only
// while no command runs. The user must write the half period register through
// csr_wr_en and csr_wr_data only while the engine is idle; the block does not enforce this.
// -----------------------------------------------------------------------------
module i2c_bit_level_master_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  i2cblm_pkg::req_item_type               req_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output i2cblm_pkg::rsp_item_type               rsp_item,
   input  logic                                   csr_wr_en,
   input  logic [i2cblm_pkg::HalfPeriodWidth-1:0] csr_wr_data
);

   logic                     tick_accept;
   i2cblm_pkg::rsp_item_type tick_result;

   assign tick_accept = req_valid && !req_stall;

   i2cblm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .tick_accept (tick_accept),
      .tick_item   (req_item),
      .tick_result (tick_result)
   );

   i2cblm_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (tick_result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_item)
   );

endmodule

// ===== tb/sv/tb_i2c_bit_level_master_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_i2c_bit_level_master_unit
// Self-checking bench for the I2C bit-level master engine. Every accepted tick
// is run through a cycle-free line-level predictor and the returned line
// levels, flags, read byte and ack are compared in order. Covers start, stop,
// write and read commands, ignored and unknown commands, several half periods
// including zero and the largest, and random gaps and stalls on both channels.
// -----------------------------------------------------------------------------
module tb_i2c_bit_level_master_unit;

   // predicts the line levels and flags of every tick and checks them in order
   class i2c_tick_scoreboard;
      logic [i2cblm_pkg::HalfPeriodWidth-1:0] half_period;
      i2cblm_pkg::phase_type   phase;
      i2cblm_pkg::command_type cmd;
      logic [3:0]  bit_count;
      logic [7:0]  shift_reg;
      logic [15:0] tick_count;
      logic        nack_choice;
      logic        scl;
      logic        sda;
      logic        ack;
      logic [7:0]  rd_byte;
      i2cblm_pkg::rsp_item_type line_levels_q[$];
      int errors;

      function new();
         half_period = i2cblm_pkg::HalfPeriodReset;
         phase       = i2cblm_pkg::PH_IDLE;
         cmd         = i2cblm_pkg::CMD_NONE;
         bit_count   = '0;
         shift_reg   = '0;
         tick_count  = '0;
         nack_choice = 1'b0;
         scl         = 1'b1;
         sda         = 1'b1;
         ack         = 1'b0;
         rd_byte     = '0;
         errors      = 0;
      endfunction

      function bit is_idle();
         return phase == i2cblm_pkg::PH_IDLE;
      endfunction

      function int pending();
         return line_levels_q.size();
      endfunction

      function void note_tick(i2cblm_pkg::req_item_type t);
         i2cblm_pkg::rsp_item_type e;
         logic [16:0] h;
         logic busy_now;
         logic done_now;
         h = (half_period == '0) ? 17'd1 : {1'b0, half_period};
         busy_now = 1'b0;
         done_now = 1'b0;
         if (phase == i2cblm_pkg::PH_IDLE && t.action >= i2cblm_pkg::CMD_START &&
             t.action <= i2cblm_pkg::CMD_READ) begin
            cmd = i2cblm_pkg::command_type'(t.action);
            nack_choice = t.send_nack;
            bit_count = '0;
            tick_count = '0;
            shift_reg = (cmd == i2cblm_pkg::CMD_WRITE) ? t.write_byte : 8'h00;
            case (cmd)
               i2cblm_pkg::CMD_START: phase = i2cblm_pkg::PH_START_A;
               i2cblm_pkg::CMD_STOP:  phase = i2cblm_pkg::PH_STOP_A;
               default:               phase = i2cblm_pkg::PH_BIT_LOW;
            endcase
         end
         if (phase == i2cblm_pkg::PH_FINISH) begin
            case (cmd)
               i2cblm_pkg::CMD_START: begin scl = 1'b0; sda = 1'b0; end
               i2cblm_pkg::CMD_STOP:  begin scl = 1'b1; sda = 1'b1; end
               default:               begin scl = 1'b0; sda = 1'b1; end
            endcase
            phase = i2cblm_pkg::PH_IDLE;
            tick_count = '0;
            done_now = 1'b1;
         end else if (phase != i2cblm_pkg::PH_IDLE) begin
            busy_now = 1'b1;
            case (phase)
               i2cblm_pkg::PH_START_A: begin scl = 1'b1; sda = 1'b1; end
               i2cblm_pkg::PH_START_B: begin scl = 1'b1; sda = 1'b0; end
               i2cblm_pkg::PH_STOP_A:  begin scl = 1'b0; sda = 1'b0; end
               i2cblm_pkg::PH_STOP_B:  begin scl = 1'b1; sda = 1'b1; end
               i2cblm_pkg::PH_BIT_LOW, i2cblm_pkg::PH_BIT_HIGH: begin
                  scl = (phase == i2cblm_pkg::PH_BIT_HIGH);
                  sda = (cmd == i2cblm_pkg::CMD_WRITE) ? shift_reg[7] : 1'b1;
               end
               i2cblm_pkg::PH_ACK_LOW, i2cblm_pkg::PH_ACK_HIGH: begin
                  scl = (phase == i2cblm_pkg::PH_ACK_HIGH);
                  sda = (cmd == i2cblm_pkg::CMD_WRITE) ? 1'b1 : nack_choice;
               end
               default: ;
            endcase
            if ({1'b0, tick_count} + 17'd1 >= h) begin
               tick_count = '0;
               case (phase)
                  i2cblm_pkg::PH_START_A: phase = i2cblm_pkg::PH_START_B;
                  i2cblm_pkg::PH_STOP_A:  phase = i2cblm_pkg::PH_STOP_B;
                  i2cblm_pkg::PH_START_B,
                  i2cblm_pkg::PH_STOP_B:  phase = i2cblm_pkg::PH_FINISH;
                  i2cblm_pkg::PH_BIT_LOW: phase = i2cblm_pkg::PH_BIT_HIGH;
                  i2cblm_pkg::PH_BIT_HIGH: begin
                     // data is sampled on the last tick of scl high
                     if (cmd == i2cblm_pkg::CMD_WRITE) shift_reg = shift_reg << 1;
                     else shift_reg = {shift_reg[6:0], t.sda_in};
                     bit_count = bit_count + 4'd1;
                     phase = (bit_count >= i2cblm_pkg::BitsPerByte) ?
                             i2cblm_pkg::PH_ACK_LOW : i2cblm_pkg::PH_BIT_LOW;
                  end
                  i2cblm_pkg::PH_ACK_LOW: phase = i2cblm_pkg::PH_ACK_HIGH;
                  i2cblm_pkg::PH_ACK_HIGH: begin
                     if (cmd == i2cblm_pkg::CMD_WRITE) ack = ~t.sda_in;
                     else rd_byte = shift_reg;
                     phase = i2cblm_pkg::PH_FINISH;
                  end
                  default: phase = i2cblm_pkg::PH_IDLE;
               endcase
            end else begin
               tick_count = tick_count + 16'd1;
            end
         end
         e.scl_level   = scl;
         e.sda_release = sda;
         e.busy_res    = busy_now;
         e.done_res    = done_now;
         e.read_byte   = rd_byte;
         e.ack_seen    = ack;
         line_levels_q.push_back(e);
      endfunction

      function void report_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
         if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                     act_val);
            errors++;
         end
      endfunction

      function void check_tick_result(i2cblm_pkg::rsp_item_type got);
         i2cblm_pkg::rsp_item_type e;
         if (line_levels_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         e = line_levels_q.pop_front();
         report_field("scl_level",   8'(e.scl_level),   8'(got.scl_level));
         report_field("sda_release", 8'(e.sda_release), 8'(got.sda_release));
         report_field("busy_res",    8'(e.busy_res),    8'(got.busy_res));
         report_field("done_res",    8'(e.done_res),    8'(got.done_res));
         report_field("read_byte",   e.read_byte,       got.read_byte);
         report_field("ack_seen",    8'(e.ack_seen),    8'(got.ack_seen));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   i2cblm_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   i2cblm_pkg::rsp_item_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [i2cblm_pkg::HalfPeriodWidth-1:0] csr_wr_data = '0;

   i2c_tick_scoreboard sb = new();
   bit no_idle = 1'b0;
   int ticks_sent = 0;
   int results_taken = 0;

   i2c_bit_level_master_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[i2c_bit_level_master_unit] ERROR");
      $finish;
   end

   // mostly no gap, some short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_tick(input i2cblm_pkg::req_item_type t);
      int gap;
      gap = no_idle ? 0 : idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= t;
      do @(posedge clock); while (req_stall);
      sb.note_tick(t);
      ticks_sent++;
   endtask

   // sda_mode: 0 line low, 1 line high, 2 random per tick
   task automatic run_command(input logic [2:0] act, input logic [7:0] wbyte,
                              input logic nack, input int sda_mode);
      i2cblm_pkg::req_item_type t;
      t.action     = act;
      t.write_byte = wbyte;
      t.send_nack  = nack;
      t.sda_in     = (sda_mode == 2) ? 1'($urandom) : sda_mode[0];
      send_tick(t);
      // commands offered while busy must be ignored
      while (!sb.is_idle()) begin
         t.action     = 3'($urandom_range(0, 7));
         t.write_byte = 8'($urandom);
         t.send_nack  = 1'($urandom);
         t.sda_in     = (sda_mode == 2) ? 1'($urandom) : sda_mode[0];
         send_tick(t);
      end
   endtask

   task automatic write_half_period(input logic [i2cblm_pkg::HalfPeriodWidth-1:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.half_period = v;
   endtask

   // receiver stalls, with one long hold-off to fill the result buffer
   initial begin
      int stall_left;
      bit held_long;
      stall_left = 0;
      held_long = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_long && results_taken >= 250) begin
            held_long = 1'b1;
            stall_left = 80;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!no_idle) stall_left = idle_len();
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_tick_result(rsp_item);
            results_taken++;
         end
      end
   end

   initial begin
      logic [i2cblm_pkg::HalfPeriodWidth-1:0] periods[6];
      int target;
      int sda_mode;
      periods = '{16'd1, 16'd0, 16'd2, 16'd7, 16'hFFFF, 16'd3};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, at the reset half period
      run_command(i2cblm_pkg::CMD_NONE, 8'h00, 1'b0, 1);
      run_command(3'd5, 8'hFF, 1'b1, 0);
      run_command(3'd6, 8'h00, 1'b0, 1);
      run_command(3'd7, 8'hFF, 1'b1, 0);
      run_command(i2cblm_pkg::CMD_START, 8'h00, 1'b0, 1);
      run_command(i2cblm_pkg::CMD_WRITE, 8'hFF, 1'b0, 0);
      run_command(i2cblm_pkg::CMD_WRITE, 8'h00, 1'b1, 1);
      run_command(i2cblm_pkg::CMD_READ, 8'h00, 1'b1, 1);
      run_command(i2cblm_pkg::CMD_READ, 8'hFF, 1'b0, 0);
      run_command(i2cblm_pkg::CMD_WRITE, 8'hA5, 1'b0, 2);
      run_command(i2cblm_pkg::CMD_READ, 8'h5A, 1'b1, 2);
      run_command(i2cblm_pkg::CMD_STOP, 8'hFF, 1'b1, 2);
      run_command(i2cblm_pkg::CMD_NONE, 8'h00, 1'b0, 2);

      foreach (periods[i]) begin
         write_half_period(periods[i]);
         no_idle = (periods[i] == 16'd2 || periods[i] == 16'hFFFF);
         if (periods[i] == 16'hFFFF) begin
            // longest segments: only items that start nothing, a command runs too long
            repeat (8) begin
               run_command(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 2);
            end
            run_command(i2cblm_pkg::CMD_NONE, 8'($urandom), 1'($urandom), 2);
         end else begin
            target = ticks_sent + ((periods[i] == 16'd7) ? 80 : 120);
            while (ticks_sent < target) begin
               sda_mode = $urandom_range(0, 5);
               if (sda_mode > 2) sda_mode = 2;
               if ($urandom_range(0, 9) < 8)
                  run_command(3'($urandom_range(i2cblm_pkg::CMD_START,
                                                i2cblm_pkg::CMD_READ)),
                              8'($urandom), 1'($urandom), sda_mode);
               else
                  run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                              sda_mode);
            end
         end
         no_idle = 1'b0;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[i2c_bit_level_master_unit] OK");
      end else begin
         $display("[i2c_bit_level_master_unit] ERROR");
      end
      $finish;
   end

endmodule
